// File: sv/srsp_pkg.sv
package srsp_pkg;

	localparam int KEY_W = 32;
	localparam int IDX_OUT_W = 6;

	typedef enum logic [5:0] {
		ST_LOAD    = 6'b000001,
		ST_RANK_LD = 6'b000010,
		ST_RANK_LI = 6'b000100,
		ST_RANK_CMP = 6'b001000,
		ST_EMIT_RD = 6'b010000,
		ST_EMIT_LD = 6'b100000
	} state_t;

endpackage

// File: sv/stable_rank_sort_permutation.sv
// stable rank sort, permutation output
// key channel: one sort_key per beat, last_key closes the set. keys past
// MAX_KEYS are dropped and raise overflow for the set.
// perm channel: after the closing beat the block emits one orig_index per
// sorted position, in rank order, with last_out on the final beat and the
// set's overflow flag on every beat.
// ranking uses one signed comparator over the key memory: for each of the
// n stored keys the sequencer fetches it, latches it, then compares it with
// each of the n stored keys in turn. after ranking, results come one at a
// time, each by a perm memory read and then an output register load.
// key_ready is low from the closing beat until the final result is loaded
// into the output register. the output register holds while perm_ready is
// low, and the sequencer waits for it. the next set may load while the
// final result is still waiting.
// reset clears the sequencer, key count, overflow flag and output valid.
// the key and perm memories are not cleared, and need not be.
module stable_rank_sort_permutation #(
	parameter int MAX_KEYS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 key_valid,
	output logic                                 key_ready,
	input  logic signed [srsp_pkg::KEY_W-1:0]    sort_key,
	input  logic                                 last_key,
	output logic                                 perm_valid,
	input  logic                                 perm_ready,
	output logic        [srsp_pkg::IDX_OUT_W-1:0] orig_index,
	output logic                                 last_out,
	output logic                                 overflow
);
	import srsp_pkg::*;

	localparam int IW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);

	state_t state_q;
	logic [CW-1:0] count_q;
	logic ovf_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic [IW-1:0] e_q;
	logic [IW-1:0] rank_q;
	logic signed [KEY_W-1:0] key_i_q;
	logic signed [KEY_W-1:0] key_rd_q;
	logic [IDX_OUT_W-1:0] perm_rd_q;
	logic signed [KEY_W-1:0] key_mem [MAX_KEYS];
	logic [IDX_OUT_W-1:0] perm_mem [MAX_KEYS];

	logic key_acc;
	logic full;
	logic [CW-1:0] last_pos;
	logic [IW-1:0] key_rd_addr;
	logic hit;
	logic [IW-1:0] rank_final;
	logic j_last;
	logic i_last;
	logic e_last;
	logic out_free;
	logic out_load;

	assign key_ready = (state_q == ST_LOAD);
	assign key_acc = key_valid && key_ready;
	assign full = (count_q == CW'(MAX_KEYS));
	assign last_pos = count_q - CW'(1);
	assign j_last = (CW'(j_q) == last_pos);
	assign i_last = (CW'(i_q) == last_pos);
	assign e_last = (CW'(e_q) == last_pos);
	assign out_free = !perm_valid || perm_ready;
	assign out_load = (state_q == ST_EMIT_LD) && out_free;

	// one shared comparator: stored key j against key i, ties by arrival
	assign hit = (key_rd_q < key_i_q) || ((key_rd_q == key_i_q) && (j_q < i_q));
	assign rank_final = rank_q + IW'(hit);

	always_comb begin
		unique case (state_q)
			ST_RANK_LD:  key_rd_addr = i_q;
			ST_RANK_CMP: key_rd_addr = j_q + IW'(1);
			default:     key_rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_acc && !full) begin
			key_mem[count_q[IW-1:0]] <= sort_key;
		end
		key_rd_q <= key_mem[key_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RANK_CMP && j_last) begin
			perm_mem[rank_final] <= IDX_OUT_W'(i_q);
		end
		if (state_q == ST_EMIT_RD) begin
			perm_rd_q <= perm_mem[e_q];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RANK_LI) begin
			key_i_q <= key_rd_q;
		end
		if (out_load) begin
			orig_index <= perm_rd_q;
			last_out   <= e_last;
			overflow   <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			e_q        <= '0;
			rank_q     <= '0;
			perm_valid <= 1'b0;
		end else begin
			perm_valid <= out_load || (perm_valid && !perm_ready);
			unique case (state_q)
				ST_LOAD: begin
					if (key_acc) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
						if (last_key) begin
							i_q     <= '0;
							state_q <= ST_RANK_LD;
						end
					end
				end
				ST_RANK_LD: begin
					state_q <= ST_RANK_LI;
				end
				ST_RANK_LI: begin
					j_q     <= '0;
					rank_q  <= '0;
					state_q <= ST_RANK_CMP;
				end
				ST_RANK_CMP: begin
					if (j_last) begin
						rank_q <= '0;
						if (i_last) begin
							e_q     <= '0;
							state_q <= ST_EMIT_RD;
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= ST_RANK_LD;
						end
					end else begin
						rank_q <= rank_final;
						j_q    <= j_q + IW'(1);
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (out_free) begin
						if (e_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							e_q     <= e_q + IW'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_KEYS))
		else $error("key count past capacity");

	a_cmp_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RANK_CMP) |-> (CW'(j_q) < count_q) && (CW'(i_q) < count_q))
		else $error("rank compare outside stored set");

	a_close_starts_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(key_acc && last_key) |=> (state_q == ST_RANK_LD) && (count_q != '0))
		else $error("closing beat did not start ranking");

	a_set_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_LD && out_free && e_last)
			|=> (count_q == '0) && !ovf_q && perm_valid && last_out)
		else $error("set not cleared after final result");

endmodule
